@@ hw/rtl/nsr_pkg.sv @@
// Shared types and constants of the nine-slice rectangle generator.
// No dependencies; every other file of the block imports this package.
package nsr_pkg;

  localparam int unsigned UV_W        = 17;  // Q1.16 texture coordinate
  localparam int unsigned CORNER_W    = 23;  // Q15.8 wanted corner size
  localparam int unsigned TEX_W       = 21;  // Q13.8 texture size
  localparam int unsigned CFG_DATA_W  = 23;  // widest register
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned KIND_W      = 4;

  // Span divider: quotient of (corner << FRAC_W) / divisor, divisor >= 2^15
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned QUOT_W      = 24;
  localparam int unsigned REM_W       = 17;
  localparam int unsigned DIV_STAGES  = 6;
  localparam int unsigned DIV_BPS     = QUOT_W / DIV_STAGES;
  localparam int unsigned LOW_BITS    = QUOT_W - FRAC_W;

  localparam logic [UV_W-1:0] ONE_Q16  = UV_W'(65536);
  localparam logic [UV_W-1:0] HALF_Q16 = UV_W'(32768);

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_U     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_V     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_HGT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT   = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    PK_CORNER_BL,
    PK_CORNER_TL,
    PK_CORNER_TR,
    PK_CORNER_BR,
    PK_EDGE_LEFT,
    PK_EDGE_RIGHT,
    PK_EDGE_BOTTOM,
    PK_EDGE_TOP,
    PK_CENTER
  } piece_kind_e;

  // Configuration as seen by the datapath, with derived values
  typedef struct packed {
    logic [UV_W-1:0]     tex_u;     // clamped center_u
    logic [UV_W-1:0]     tex_v;     // one minus clamped center_v
    logic [UV_W-1:0]     div_x;     // max(cu, 1 - cu)
    logic [UV_W-1:0]     div_y;     // max(cv, 1 - cv)
    logic [CORNER_W-1:0] corner_w;
    logic [CORNER_W-1:0] corner_h;
    logic [TEX_W-1:0]    tex_w;
    logic [TEX_W-1:0]    tex_h;
  } cfg_t;

  typedef struct packed {
    logic sides;  // left/right edge pair fits
    logic caps;   // bottom/top edge pair fits
  } split_flags_t;

endpackage

@@ hw/rtl/nsr_cfg_regs.sv @@
// Configuration register file of the nine-slice generator, with clamping
// and divisor selection. Depends on nsr_pkg.
module nsr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output nsr_pkg::cfg_t                 cfg_o
);
  import nsr_pkg::*;

  logic [UV_W-1:0]     center_u_q, center_v_q;
  logic [CORNER_W-1:0] corner_w_q, corner_h_q;
  logic [TEX_W-1:0]    tex_w_q, tex_h_q;
  logic [UV_W-1:0]     cu, cv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_u_q <= HALF_Q16;
      center_v_q <= HALF_Q16;
      corner_w_q <= '0;
      corner_h_q <= '0;
      tex_w_q    <= TEX_W'(65536);
      tex_h_q    <= TEX_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_U:     center_u_q <= cfg_wdata_i[UV_W-1:0];
        REG_CENTER_V:     center_v_q <= cfg_wdata_i[UV_W-1:0];
        REG_CORNER_WIDTH: corner_w_q <= cfg_wdata_i[CORNER_W-1:0];
        REG_CORNER_HGT:   corner_h_q <= cfg_wdata_i[CORNER_W-1:0];
        REG_TEX_WIDTH:    tex_w_q    <= cfg_wdata_i[TEX_W-1:0];
        REG_TEX_HEIGHT:   tex_h_q    <= cfg_wdata_i[TEX_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp split points to one
  assign cu = (center_u_q > ONE_Q16) ? ONE_Q16 : center_u_q;
  assign cv = (center_v_q > ONE_Q16) ? ONE_Q16 : center_v_q;

  always_comb begin
    cfg_o.tex_u    = cu;
    cfg_o.tex_v    = ONE_Q16 - cv;
    cfg_o.div_x    = (cu > HALF_Q16) ? cu : ONE_Q16 - cu;
    cfg_o.div_y    = (cv > HALF_Q16) ? cv : ONE_Q16 - cv;
    cfg_o.corner_w = corner_w_q;
    cfg_o.corner_h = corner_h_q;
    cfg_o.tex_w    = tex_w_q;
    cfg_o.tex_h    = tex_h_q;
  end

endmodule

@@ hw/rtl/nsr_span_div.sv @@
// Pipelined restoring divider for the corner span: (corner << 16) / divisor.
// Depends on nsr_pkg; stage advance comes from the block's pipeline control.
module nsr_span_div (
  input  logic                         clk_i,
  input  logic [nsr_pkg::DIV_STAGES-1:0] adv_i,
  input  logic [nsr_pkg::CORNER_W-1:0] corner_i,
  input  logic [nsr_pkg::UV_W-1:0]     divisor_i,
  output logic [nsr_pkg::QUOT_W-1:0]   quot_o
);
  import nsr_pkg::*;

  logic [REM_W-1:0]  rem_q [DIV_STAGES];
  logic [QUOT_W-1:0] quo_q [DIV_STAGES];
  logic [QUOT_W-1:0] num_low;

  // Bits of the shifted dividend that the quotient still needs
  assign num_low = {corner_i[LOW_BITS-1:0], {FRAC_W{1'b0}}};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in, rem_d;
    logic [QUOT_W-1:0] quo_in, quo_d;

    if (k == 0) begin : g_first
      assign rem_in = REM_W'(corner_i[CORNER_W-1:LOW_BITS]);
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [REM_W:0] trial;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int i = 0; i < DIV_BPS; i++) begin
        trial = {rem_d, num_low[QUOT_W-1-(k*DIV_BPS+i)]};
        if (trial >= {1'b0, divisor_i}) begin
          rem_d = REM_W'(trial - {1'b0, divisor_i});
          quo_d = {quo_d[QUOT_W-2:0], 1'b1};
        end else begin
          rem_d = trial[REM_W-1:0];
          quo_d = {quo_d[QUOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[k]) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quot_o = quo_q[DIV_STAGES-1];

endmodule

@@ hw/rtl/nsr_piece_seq.sv @@
// Piece sequencer: holds one split box and emits its pieces one per cycle while out_ready_i is high.
// Depends on nsr_pkg.
module nsr_piece_seq #(
  parameter int unsigned CW = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nsr_pkg::cfg_t                 cfg_i,
  input  logic                          box_valid_i,
  output logic                          box_ready_o,
  input  logic signed [CW-1:0]          l_i,
  input  logic signed [CW-1:0]          b_i,
  input  logic signed [CW-1:0]          r_i,
  input  logic signed [CW-1:0]          t_i,
  input  logic signed [CW-1:0]          lm_i,
  input  logic signed [CW-1:0]          bm_i,
  input  logic signed [CW-1:0]          rm_i,
  input  logic signed [CW-1:0]          tm_i,
  input  nsr_pkg::split_flags_t         flags_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [CW-1:0]          rect_left_o,
  output logic signed [CW-1:0]          rect_bottom_o,
  output logic signed [CW-1:0]          rect_right_o,
  output logic signed [CW-1:0]          rect_top_o,
  output logic [nsr_pkg::UV_W-1:0]      u_first_o,
  output logic [nsr_pkg::UV_W-1:0]      v_first_o,
  output logic [nsr_pkg::UV_W-1:0]      u_second_o,
  output logic [nsr_pkg::UV_W-1:0]      v_second_o,
  output logic [nsr_pkg::KIND_W-1:0]    piece_kind_o,
  output logic                          last_piece_o
);
  import nsr_pkg::*;

  logic                 busy_q;
  piece_kind_e          kind_q, kind_d;
  logic signed [CW-1:0] l_q, b_q, r_q, t_q, lm_q, bm_q, rm_q, tm_q;
  split_flags_t         flags_q;
  logic                 last;
  logic                 load;
  logic [UV_W-1:0]      tu, tv;

  assign tu = cfg_i.tex_u;
  assign tv = cfg_i.tex_v;

  always_comb begin
    unique case (kind_q)
      PK_CORNER_BR: last = !flags_q.sides && !flags_q.caps;
      PK_EDGE_RIGHT: last = !flags_q.caps;
      PK_EDGE_TOP:  last = !flags_q.sides;
      PK_CENTER:    last = 1'b1;
      default:      last = 1'b0;
    endcase
  end

  always_comb begin
    unique case (kind_q)
      PK_CORNER_BR:  kind_d = flags_q.sides ? PK_EDGE_LEFT : PK_EDGE_BOTTOM;
      PK_EDGE_RIGHT: kind_d = flags_q.caps ? PK_EDGE_BOTTOM : PK_CENTER;
      default:       kind_d = piece_kind_e'(kind_q + KIND_W'(1));
    endcase
  end

  assign box_ready_o = !busy_q || (out_ready_i && last);
  assign load        = box_valid_i && box_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= PK_CORNER_BL;
    end else if (load) begin
      busy_q <= 1'b1;
      kind_q <= PK_CORNER_BL;
    end else if (busy_q && out_ready_i) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        kind_q <= kind_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      l_q     <= l_i;
      b_q     <= b_i;
      r_q     <= r_i;
      t_q     <= t_i;
      lm_q    <= lm_i;
      bm_q    <= bm_i;
      rm_q    <= rm_i;
      tm_q    <= tm_i;
      flags_q <= flags_i;
    end
  end

  always_comb begin
    unique case (kind_q)
      PK_CORNER_BL: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {l_q, b_q, lm_q, bm_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {UV_W'(0), ONE_Q16, tu, tv};
      end
      PK_CORNER_TL: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {l_q, tm_q, lm_q, t_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {UV_W'(0), tv, tu, UV_W'(0)};
      end
      PK_CORNER_TR: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {rm_q, tm_q, r_q, t_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {tu, tv, ONE_Q16, UV_W'(0)};
      end
      PK_CORNER_BR: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {rm_q, b_q, r_q, bm_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {tu, ONE_Q16, ONE_Q16, tv};
      end
      PK_EDGE_LEFT: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {l_q, bm_q, lm_q, tm_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {UV_W'(0), tv, tu, tv};
      end
      PK_EDGE_RIGHT: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {rm_q, bm_q, r_q, tm_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {tu, tv, ONE_Q16, tv};
      end
      PK_EDGE_BOTTOM: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {lm_q, b_q, rm_q, bm_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {tu, ONE_Q16, tu, tv};
      end
      PK_EDGE_TOP: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {lm_q, tm_q, rm_q, t_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {tu, tv, tu, UV_W'(0)};
      end
      default: begin
        {rect_left_o, rect_bottom_o, rect_right_o, rect_top_o} = {lm_q, bm_q, rm_q, tm_q};
        {u_first_o, v_first_o, u_second_o, v_second_o} = {tu, tv, tu, tv};
      end
    endcase
  end

  assign out_valid_o  = busy_q;
  assign piece_kind_o = kind_q;
  assign last_piece_o = last;

endmodule

@@ hw/rtl/nine_slice_rect_generator.sv @@
// Top level of the nine-slice rectangle generator: box pipeline and split math.
// Depends on nsr_pkg, nsr_cfg_regs, nsr_span_div and nsr_piece_seq.
//
//   channel   direction  handshake                     payload
//   box in    input      in_valid_i / in_ready_o       box_left_i .. box_top_i
//   piece out output     out_valid_o / out_ready_i     rect_*_o, u/v_*_o, kind, last
//   config    input      cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// Boxes enter one per cycle, unless the pipeline is stalled, into an eight-stage
// pipeline (six divider stages, a size stage and a split stage) and leave as four
// to nine pieces, one per cycle while out_ready_i is high; the piece sequencer
// sets the sustained rate. A box's first piece is offered once the box has passed
// the split stage and been loaded into the piece sequencer.
// Reset clears the valid bits and loads the register defaults; no sweep.
// A stall at the output backs up stage by stage; nothing is dropped or repeated.
module nine_slice_rect_generator #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]  box_left_i,
  input  logic signed [COORD_WIDTH-1:0]  box_bottom_i,
  input  logic signed [COORD_WIDTH-1:0]  box_right_i,
  input  logic signed [COORD_WIDTH-1:0]  box_top_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [COORD_WIDTH-1:0]  rect_left_o,
  output logic signed [COORD_WIDTH-1:0]  rect_bottom_o,
  output logic signed [COORD_WIDTH-1:0]  rect_right_o,
  output logic signed [COORD_WIDTH-1:0]  rect_top_o,
  output logic [nsr_pkg::UV_W-1:0]       u_first_o,
  output logic [nsr_pkg::UV_W-1:0]       v_first_o,
  output logic [nsr_pkg::UV_W-1:0]       u_second_o,
  output logic [nsr_pkg::UV_W-1:0]       v_second_o,
  output logic [nsr_pkg::KIND_W-1:0]     piece_kind_o,
  output logic                           last_piece_o
);
  import nsr_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  // Signed width that holds both a box size and an unsigned span
  localparam int unsigned SW  = (CW + 1 > QUOT_W + 1) ? CW + 1 : QUOT_W + 1;
  localparam int unsigned NST = DIV_STAGES + 2;
  localparam int unsigned SZ  = DIV_STAGES;      // size stage
  localparam int unsigned SP  = DIV_STAGES + 1;  // split stage

  cfg_t cfg;

  logic [NST-1:0]       vld_q;
  logic [NST-1:0]       rdy;
  logic signed [CW-1:0] l_q [NST];
  logic signed [CW-1:0] b_q [NST];
  logic signed [CW-1:0] r_q [NST];
  logic signed [CW-1:0] t_q [NST];
  logic                 seq_ready;

  logic [QUOT_W-1:0]    quot_x, quot_y;

  logic [QUOT_W-1:0]    span_x_d, span_y_d, span_x_q, span_y_q;
  logic signed [SW-1:0] size_x_d, size_y_d, size_x_q, size_y_q;

  logic signed [CW-1:0] lm_d, rm_d, bm_d, tm_d, lm_q, rm_q, bm_q, tm_q;
  split_flags_t         flags_d, flags_q;

  nsr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Ready ripples back from the sequencer: a stage takes new data when empty
  // or when its content moves on in the same cycle.
  always_comb begin
    for (int k = NST - 1; k >= 0; k--) begin
      if (k == NST - 1) begin
        rdy[k] = !vld_q[k] || seq_ready;
      end else begin
        rdy[k] = !vld_q[k] || rdy[k+1];
      end
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[k-1];
        end
      end
    end
  end

  // Box coordinates travel alongside the divider
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        if (k == 0) begin
          l_q[k] <= box_left_i;
          b_q[k] <= box_bottom_i;
          r_q[k] <= box_right_i;
          t_q[k] <= box_top_i;
        end else begin
          l_q[k] <= l_q[k-1];
          b_q[k] <= b_q[k-1];
          r_q[k] <= r_q[k-1];
          t_q[k] <= t_q[k-1];
        end
      end
    end
  end

  // Corner spans from the wanted corner size
  nsr_span_div u_div_x (
    .clk_i     (clk_i),
    .adv_i     (rdy[DIV_STAGES-1:0]),
    .corner_i  (cfg.corner_w),
    .divisor_i (cfg.div_x),
    .quot_o    (quot_x)
  );

  nsr_span_div u_div_y (
    .clk_i     (clk_i),
    .adv_i     (rdy[DIV_STAGES-1:0]),
    .corner_i  (cfg.corner_h),
    .divisor_i (cfg.div_y),
    .quot_o    (quot_y)
  );

  // Size stage: pick span, take box width and height
  always_comb begin
    span_x_d = (cfg.corner_w == '0) ? QUOT_W'(cfg.tex_w) : quot_x;
    span_y_d = (cfg.corner_h == '0) ? QUOT_W'(cfg.tex_h) : quot_y;
    size_x_d = SW'(r_q[SZ-1]) - SW'(l_q[SZ-1]);
    size_y_d = SW'(t_q[SZ-1]) - SW'(b_q[SZ-1]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SZ]) begin
      span_x_q <= span_x_d;
      span_y_q <= span_y_d;
      size_x_q <= size_x_d;
      size_y_q <= size_y_d;
    end
  end

  // Split stage: an edge pair fits when its span does not exceed the box;
  // otherwise both split lines meet at the floor midpoint.
  always_comb begin
    logic signed [SW-1:0] sx, sy;
    sx = $signed(SW'(span_x_q));
    sy = $signed(SW'(span_y_q));
    flags_d.caps  = !(sx > size_x_q);
    flags_d.sides = !(sy > size_y_q);
    if (flags_d.caps) begin
      lm_d = CW'(SW'(l_q[SZ]) + (sx >>> 1));
      rm_d = CW'(SW'(r_q[SZ]) - (sx >>> 1));
    end else begin
      lm_d = CW'(SW'(l_q[SZ]) + (size_x_q >>> 1));
      rm_d = lm_d;
    end
    if (flags_d.sides) begin
      bm_d = CW'(SW'(b_q[SZ]) + (sy >>> 1));
      tm_d = CW'(SW'(t_q[SZ]) - (sy >>> 1));
    end else begin
      bm_d = CW'(SW'(b_q[SZ]) + (size_y_q >>> 1));
      tm_d = bm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SP]) begin
      lm_q    <= lm_d;
      rm_q    <= rm_d;
      bm_q    <= bm_d;
      tm_q    <= tm_d;
      flags_q <= flags_d;
    end
  end

  nsr_piece_seq #(
    .CW (CW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .box_valid_i   (vld_q[SP]),
    .box_ready_o   (seq_ready),
    .l_i           (l_q[SP]),
    .b_i           (b_q[SP]),
    .r_i           (r_q[SP]),
    .t_i           (t_q[SP]),
    .lm_i          (lm_q),
    .bm_i          (bm_q),
    .rm_i          (rm_q),
    .tm_i          (tm_q),
    .flags_i       (flags_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rect_left_o   (rect_left_o),
    .rect_bottom_o (rect_bottom_o),
    .rect_right_o  (rect_right_o),
    .rect_top_o    (rect_top_o),
    .u_first_o     (u_first_o),
    .v_first_o     (v_first_o),
    .u_second_o    (u_second_o),
    .v_second_o    (v_second_o),
    .piece_kind_o  (piece_kind_o),
    .last_piece_o  (last_piece_o)
  );

endmodule
